>>> rtl/sst_pkg.sv
// Shared types and constants for the script source tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

  localparam int unsigned OffsetBits = 16;
  localparam logic [OffsetBits-1:0] OffsetMax = '1;

  localparam logic [39:0] KwWhile = 40'h7768696C65;
  localparam logic [39:0] KwIf    = 40'h0000006966;
  localparam logic [39:0] KwElse  = 40'h00656C7365;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_IDENT   = 4'd1,
    MODE_NUMBER  = 4'd2,
    MODE_COMMENT = 4'd3,
    MODE_EQ      = 4'd4,
    MODE_BANG    = 4'd5,
    MODE_LT      = 4'd6,
    MODE_GT      = 4'd7,
    MODE_AMP     = 4'd8,
    MODE_BAR     = 4'd9,
    MODE_SLASH   = 4'd10
  } mode_e;

  typedef enum logic [4:0] {
    TK_IDENT    = 5'd0,
    TK_NUMBER   = 5'd1,
    TK_WHILE    = 5'd2,
    TK_IF       = 5'd3,
    TK_ELSE     = 5'd4,
    TK_ASSIGN   = 5'd5,
    TK_EQ       = 5'd6,
    TK_NOT      = 5'd7,
    TK_NE       = 5'd8,
    TK_LT       = 5'd9,
    TK_LE       = 5'd10,
    TK_GT       = 5'd11,
    TK_GE       = 5'd12,
    TK_LAND     = 5'd13,
    TK_LOR      = 5'd14,
    TK_MOD      = 5'd15,
    TK_PLUS     = 5'd16,
    TK_MINUS    = 5'd17,
    TK_STAR     = 5'd18,
    TK_DIV      = 5'd19,
    TK_LPAREN   = 5'd20,
    TK_RPAREN   = 5'd21,
    TK_LBRACE   = 5'd22,
    TK_RBRACE   = 5'd23,
    TK_LBRACKET = 5'd24,
    TK_RBRACKET = 5'd25,
    TK_SEMI     = 5'd26,
    TK_COMMA    = 5'd27,
    TK_UNKNOWN  = 5'd28,
    TK_END      = 5'd29
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e             kind;
    logic [OffsetBits-1:0] start;
    logic [OffsetBits-1:0] len;
    logic [7:0]            ch;
    logic                  last;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } push_t;

endpackage

`default_nettype wire

>>> rtl/sst_scan.sv
// Scanner state and per-byte token logic.
`timescale 1ns / 1ps
`default_nettype none

module sst_scan (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            fire_i,
  input  wire logic [7:0]      char_i,
  input  wire logic            eos_i,
  output sst_pkg::push_t       push_o
);

  sst_pkg::mode_e                  mode_q, mode_d;
  logic [sst_pkg::OffsetBits-1:0]  pos_q, pos_d;
  logic [sst_pkg::OffsetBits-1:0]  pstart_q, pstart_d;
  logic [sst_pkg::OffsetBits-1:0]  plen_q, plen_d;
  logic [39:0]                     prefix_q, prefix_d;

  sst_pkg::tok_t a, b, f;
  logic          a_v, b_v, f_v, consumed, start_tok;

  function automatic logic [sst_pkg::OffsetBits-1:0] sat_inc(
    input logic [sst_pkg::OffsetBits-1:0] v);
    return (v == sst_pkg::OffsetMax) ? v : v + 1'b1;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic sst_pkg::tok_kind_e single_kind(input logic [7:0] c);
    sst_pkg::tok_kind_e k;
    case (c)
      "%":     k = sst_pkg::TK_MOD;
      "+":     k = sst_pkg::TK_PLUS;
      "-":     k = sst_pkg::TK_MINUS;
      "*":     k = sst_pkg::TK_STAR;
      "(":     k = sst_pkg::TK_LPAREN;
      ")":     k = sst_pkg::TK_RPAREN;
      "{":     k = sst_pkg::TK_LBRACE;
      "}":     k = sst_pkg::TK_RBRACE;
      "[":     k = sst_pkg::TK_LBRACKET;
      "]":     k = sst_pkg::TK_RBRACKET;
      ";":     k = sst_pkg::TK_SEMI;
      ",":     k = sst_pkg::TK_COMMA;
      default: k = sst_pkg::TK_UNKNOWN;
    endcase
    return k;
  endfunction

  // Pending token as it stands, with no continuation byte.
  always_comb begin
    f       = '0;
    f_v     = 1'b1;
    f.start = pstart_q;
    f.len   = sst_pkg::OffsetBits'(1);
    case (mode_q)
      sst_pkg::MODE_IDENT: begin
        f.len = plen_q;
        if (plen_q == sst_pkg::OffsetBits'(5) && prefix_q == sst_pkg::KwWhile) begin
          f.kind = sst_pkg::TK_WHILE;
        end else if (plen_q == sst_pkg::OffsetBits'(2) && prefix_q == sst_pkg::KwIf) begin
          f.kind = sst_pkg::TK_IF;
        end else if (plen_q == sst_pkg::OffsetBits'(4) && prefix_q == sst_pkg::KwElse) begin
          f.kind = sst_pkg::TK_ELSE;
        end else begin
          f.kind = sst_pkg::TK_IDENT;
        end
      end
      sst_pkg::MODE_NUMBER: begin
        f.kind = sst_pkg::TK_NUMBER;
        f.len  = plen_q;
      end
      sst_pkg::MODE_EQ:    f.kind = sst_pkg::TK_ASSIGN;
      sst_pkg::MODE_BANG:  f.kind = sst_pkg::TK_NOT;
      sst_pkg::MODE_LT:    f.kind = sst_pkg::TK_LT;
      sst_pkg::MODE_GT:    f.kind = sst_pkg::TK_GT;
      sst_pkg::MODE_AMP: begin
        f.kind = sst_pkg::TK_UNKNOWN;
        f.ch   = "&";
      end
      sst_pkg::MODE_BAR: begin
        f.kind = sst_pkg::TK_UNKNOWN;
        f.ch   = "|";
      end
      sst_pkg::MODE_SLASH: f.kind = sst_pkg::TK_DIV;
      default:             f_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    pos_d     = sat_inc(pos_q);
    pstart_d  = pstart_q;
    plen_d    = plen_q;
    prefix_d  = prefix_q;
    a         = '0;
    b         = '0;
    a_v       = 1'b0;
    b_v       = 1'b0;
    consumed  = 1'b0;
    start_tok = 1'b0;

    if (eos_i || char_i == 8'd0) begin
      a        = f;
      a_v      = f_v;
      b.kind   = sst_pkg::TK_END;
      b.start  = pos_q;
      b_v      = 1'b1;
      mode_d   = sst_pkg::MODE_IDLE;
      pos_d    = '0;
      pstart_d = '0;
      plen_d   = '0;
      prefix_d = '0;
    end else begin
      a.start = pstart_q;
      a.len   = sst_pkg::OffsetBits'(2);
      case (mode_q)
        sst_pkg::MODE_IDENT: begin
          if (is_alpha(char_i) || is_digit(char_i) || char_i == "_") begin
            if (plen_q < sst_pkg::OffsetBits'(5)) begin
              prefix_d = {prefix_q[31:0], char_i};
            end
            plen_d   = sat_inc(plen_q);
            consumed = 1'b1;
          end
        end
        sst_pkg::MODE_NUMBER: begin
          if (is_digit(char_i) || char_i == ".") begin
            plen_d   = sat_inc(plen_q);
            consumed = 1'b1;
          end
        end
        sst_pkg::MODE_COMMENT: begin
          if (char_i == 8'h0A) begin
            mode_d = sst_pkg::MODE_IDLE;
          end
          consumed = 1'b1;
        end
        sst_pkg::MODE_EQ, sst_pkg::MODE_BANG, sst_pkg::MODE_LT, sst_pkg::MODE_GT: begin
          if (char_i == "=") begin
            case (mode_q)
              sst_pkg::MODE_EQ:   a.kind = sst_pkg::TK_EQ;
              sst_pkg::MODE_BANG: a.kind = sst_pkg::TK_NE;
              sst_pkg::MODE_LT:   a.kind = sst_pkg::TK_LE;
              default:            a.kind = sst_pkg::TK_GE;
            endcase
            a_v      = 1'b1;
            mode_d   = sst_pkg::MODE_IDLE;
            consumed = 1'b1;
          end
        end
        sst_pkg::MODE_AMP: begin
          if (char_i == "&") begin
            a.kind   = sst_pkg::TK_LAND;
            a_v      = 1'b1;
            mode_d   = sst_pkg::MODE_IDLE;
            consumed = 1'b1;
          end
        end
        sst_pkg::MODE_BAR: begin
          if (char_i == "|") begin
            a.kind   = sst_pkg::TK_LOR;
            a_v      = 1'b1;
            mode_d   = sst_pkg::MODE_IDLE;
            consumed = 1'b1;
          end
        end
        sst_pkg::MODE_SLASH: begin
          if (char_i == "/") begin
            mode_d   = sst_pkg::MODE_COMMENT;
            consumed = 1'b1;
          end
        end
        default: mode_d = sst_pkg::MODE_IDLE;
      endcase

      if (!consumed) begin
        a      = f;
        a_v    = f_v;
        mode_d = sst_pkg::MODE_IDLE;
        if (is_space(char_i)) begin
          mode_d = sst_pkg::MODE_IDLE;
        end else if (is_alpha(char_i) || char_i == "_") begin
          mode_d    = sst_pkg::MODE_IDENT;
          start_tok = 1'b1;
        end else if (is_digit(char_i) || char_i == ".") begin
          mode_d    = sst_pkg::MODE_NUMBER;
          start_tok = 1'b1;
        end else begin
          case (char_i)
            "=": begin
              mode_d    = sst_pkg::MODE_EQ;
              start_tok = 1'b1;
            end
            "!": begin
              mode_d    = sst_pkg::MODE_BANG;
              start_tok = 1'b1;
            end
            "<": begin
              mode_d    = sst_pkg::MODE_LT;
              start_tok = 1'b1;
            end
            ">": begin
              mode_d    = sst_pkg::MODE_GT;
              start_tok = 1'b1;
            end
            "&": begin
              mode_d    = sst_pkg::MODE_AMP;
              start_tok = 1'b1;
            end
            "|": begin
              mode_d    = sst_pkg::MODE_BAR;
              start_tok = 1'b1;
            end
            "/": begin
              mode_d    = sst_pkg::MODE_SLASH;
              start_tok = 1'b1;
            end
            default: begin
              b.kind  = single_kind(char_i);
              b.start = pos_q;
              b.len   = sst_pkg::OffsetBits'(1);
              b.ch    = (b.kind == sst_pkg::TK_UNKNOWN) ? char_i : 8'd0;
              b_v     = 1'b1;
            end
          endcase
        end
        if (start_tok) begin
          pstart_d = pos_q;
          plen_d   = sst_pkg::OffsetBits'(1);
          prefix_d = {32'd0, char_i};
        end
      end
    end
  end

  // Pack up to two tokens, flushed one first.
  always_comb begin
    push_o = '0;
    if (a_v) begin
      push_o.t0      = a;
      push_o.t0.last = !b_v;
      push_o.t1      = b;
      push_o.t1.last = 1'b1;
      push_o.cnt     = b_v ? 2'd2 : 2'd1;
    end else begin
      push_o.t0      = b;
      push_o.t0.last = 1'b1;
      push_o.cnt     = b_v ? 2'd1 : 2'd0;
    end
    if (!fire_i) begin
      push_o.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= sst_pkg::MODE_IDLE;
      pos_q    <= '0;
      pstart_q <= '0;
      plen_q   <= '0;
      prefix_q <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      prefix_q <= prefix_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/sst_out_buf.sv
// Four-entry token buffer: up to two writes and one read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sst_out_buf (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sst_pkg::push_t  push_i,
  output logic                 room_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output sst_pkg::tok_t        out_tok_o
);

  sst_pkg::tok_t mem_q [4];
  logic [1:0]    wr_q, rd_q;
  logic [2:0]    cnt_q, cnt_d;
  logic          pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != 3'd0;
  assign out_tok_o   = mem_q[rd_q];
  assign room_o      = cnt_q <= 3'd2;
  assign cnt_d       = cnt_q + {1'b0, push_i.cnt} - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.t0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.t1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.cnt;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/script_source_tokenizer_core.sv
// Top level of the streaming source tokenizer.
//
// Input channel: one source byte per transfer (char_code_i), or an end marker
// (end_of_source_i, or a zero byte) that flushes the pending token, emits an
// end token and clears the scanner. Output channel: one token per transfer,
// given as kind, start offset, length, the byte of an unknown token, and
// last_o on the final token caused by an input byte.
// A byte sits in the input register until it is scanned there, and its
// zero, one or two tokens are written to a four-entry output buffer; the
// first token of a byte is presented from that buffer once written there.
// Throughput is one byte per cycle while the receiver keeps up; any byte is
// scanned only when two buffer slots are free, so a byte stream dense in
// two-token bytes is limited by the single output port.
// Reset clears the scanner, offset counter and buffer. When the receiver
// stalls the buffer fills and input ready drops; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module script_source_tokenizer_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        end_of_source_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       token_kind_o,
  output logic [15:0]      start_offset_o,
  output logic [15:0]      token_length_o,
  output logic [7:0]       token_char_o,
  output logic             last_o
);

  logic           iv_q;
  logic [7:0]     char_q;
  logic           eos_q;
  logic           room, proc;
  sst_pkg::push_t push;
  sst_pkg::tok_t  tok;

  assign proc       = iv_q && room;
  assign in_ready_o = !iv_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_ready_o) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= char_code_i;
      eos_q  <= end_of_source_i;
    end
  end

  sst_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (proc),
    .char_i (char_q),
    .eos_i  (eos_q),
    .push_o (push)
  );

  sst_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_tok_o   (tok)
  );

  assign token_kind_o   = tok.kind;
  assign start_offset_o = tok.start;
  assign token_length_o = tok.len;
  assign token_char_o   = tok.ch;
  assign last_o         = tok.last;

endmodule

`default_nettype wire
